/* rtl/box_overlap_accumulator_assert.svh */
// ----------------------------------------------------------------------------
// Box overlap accumulator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_OVERLAP_ACCUMULATOR_ASSERT_SVH
`define BOX_OVERLAP_ACCUMULATOR_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define BOVL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BOVL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/bovl_pkg.sv */
// ----------------------------------------------------------------------------
// Box overlap accumulator package
// Widths, item and result types, and helper functions for the block.
// ----------------------------------------------------------------------------
package bovl_pkg;

   localparam int COORD_BITS  = 32;
   localparam int VOLUME_BITS = 64;
   localparam int MAX_DIMS    = 8;
   localparam int LOG_SUM_BITS = 8;

   localparam int LOG_BITS = (COORD_BITS > 2) ? $clog2(COORD_BITS) : 1;
   localparam int DIM_BITS = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [DIM_BITS-1:0] DIM_LAST = DIM_BITS'(MAX_DIMS - 1);

   localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RESULT_BITS   = 5 + LOG_SUM_BITS + 2 * VOLUME_BITS;
   localparam int OUT_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

   localparam logic [VOLUME_BITS-1:0] VOL_MAX = {VOLUME_BITS{1'b1}};
   localparam logic [VOLUME_BITS-1:0] VOL_ONE = VOLUME_BITS'(1);
   localparam logic [LOG_SUM_BITS-1:0] LOG_SUM_MAX = {LOG_SUM_BITS{1'b1}};

   typedef struct packed {
      logic [COORD_BITS-1:0] high_two;
      logic [COORD_BITS-1:0] low_two;
      logic [COORD_BITS-1:0] high_one;
      logic [COORD_BITS-1:0] low_one;
   } item_type;

   typedef struct packed {
      logic enable;
      logic last_dim;
   } step_type;

   typedef struct packed {
      logic                    bad_bounds;
      logic                    box_overflow;
      logic [VOLUME_BITS-1:0]  box_volume;
      logic                    overlap_overflow;
      logic [VOLUME_BITS-1:0]  overlap_volume;
      logic [LOG_SUM_BITS-1:0] overlap_log_sum;
      logic                    second_inside_first;
      logic                    intersects;
   } result_type;

   function automatic logic [LOG_BITS-1:0] floor_log2(input logic [COORD_BITS-1:0] value);
      logic [LOG_BITS-1:0] pos;
      pos = '0;
      for (int i = 1; i < COORD_BITS; i++) begin
         if (value[i]) begin
            pos = LOG_BITS'(i);
         end
      end
      return pos;
   endfunction

endpackage

/* rtl/box_overlap_accumulator.sv */
// ----------------------------------------------------------------------------
// Box overlap accumulator
// Compares two axis-aligned boxes one dimension per item on the req stream
// and returns one summary item per box pair on the rsp stream.
//
// Each req item carries the low and high bounds of both boxes in one
// dimension; req_tlast marks the closing dimension, and the dimension that
// reaches the maximum dimension count closes the pair as well. Only the
// closing item produces a rsp item.
// A closing item is held first in the input register and then in the output
// register, from which its result is presented on rsp_tvalid.
// Throughput: one item per cycle unless a closing item meets a stalled output;
// the accumulation stage does one split multiply per dimension on the products.
// Reset clears all running state and empties both registers.
// When the receiver stalls, the result stays in the output register; further
// non-closing items keep flowing, and a closing item waits in the input
// register, which in turn drops req_tready.
// ----------------------------------------------------------------------------
module box_overlap_accumulator
   import bovl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // low_one, high_one, low_two, high_two from the lowest bit up
   input  logic [IN_DATA_BITS-1:0]  req_tdata,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // intersects, second_inside_first, overlap_log_sum, overlap_volume,
   // overlap_overflow, box_volume, box_overflow, bad_bounds from the lowest bit up
   output logic [OUT_DATA_BITS-1:0] rsp_tdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   step_type   step;
   logic       finish;
   logic       advance;
   result_type result;

   assign advance    = in_valid_ff && (!finish || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = (advance && finish) || (out_valid_ff && !rsp_tready);

   assign step.enable   = advance;
   assign step.last_dim = last_ff;

   bovl_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .finish (finish),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_type'(req_tdata[4*COORD_BITS-1:0]);
         last_ff <= req_tlast;
      end
      if (advance && finish) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_DATA_BITS'(result_ff);

endmodule

/* rtl/bovl_sat_mul.sv */
// ----------------------------------------------------------------------------
// Saturating product step
// Multiplies a running product by one coordinate-wide factor, saturating
// at the volume width with a sticky overflow flag; a zero factor clears both.
// ----------------------------------------------------------------------------
module bovl_sat_mul
   import bovl_pkg::*;
(
   input  logic [VOLUME_BITS-1:0] prod,
   input  logic                   ovf,
   input  logic [COORD_BITS-1:0]  factor,
   output logic [VOLUME_BITS-1:0] prod_next,
   output logic                   ovf_next
);

   localparam int LO_BITS  = VOLUME_BITS / 2;
   localparam int HI_BITS  = VOLUME_BITS - LO_BITS;
   localparam int A_BITS   = HI_BITS + COORD_BITS;
   localparam int B_BITS   = LO_BITS + COORD_BITS;
   localparam int SUM_BITS = ((HI_BITS > COORD_BITS) ? HI_BITS : COORD_BITS) + 1;

   logic [A_BITS-1:0]   part_hi;
   logic [B_BITS-1:0]   part_lo;
   logic [SUM_BITS-1:0] upper_sum;
   logic                too_big;

   // The product splits into a high and a low half so that each partial
   // product stays within one coordinate-by-half-volume multiplier.
   assign part_hi = A_BITS'(prod[VOLUME_BITS-1:LO_BITS]) * A_BITS'(factor);
   assign part_lo = B_BITS'(prod[LO_BITS-1:0]) * B_BITS'(factor);
   assign upper_sum = SUM_BITS'(part_hi[HI_BITS-1:0]) + SUM_BITS'(part_lo[B_BITS-1:LO_BITS]);
   assign too_big = (|part_hi[A_BITS-1:HI_BITS]) | (|upper_sum[SUM_BITS-1:HI_BITS]);

   always_comb begin
      prod_next = prod;
      ovf_next  = ovf;
      if (factor == '0) begin
         prod_next = '0;
         ovf_next  = 1'b0;
      end else if (!ovf && (prod != '0)) begin
         if (too_big) begin
            prod_next = VOL_MAX;
            ovf_next  = 1'b1;
         end else begin
            prod_next = {upper_sum[HI_BITS-1:0], part_lo[LO_BITS-1:0]};
         end
      end
   end

endmodule

/* rtl/bovl_accum.sv */
// ----------------------------------------------------------------------------
// Box overlap accumulation stage
// Compares one dimension of the box pair, updates the running flags, log
// sum and products, and forms the result on the closing dimension.
// ----------------------------------------------------------------------------
module bovl_accum
   import bovl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   input  item_type   item,
   output logic       finish,
   output result_type result
);

`include "box_overlap_accumulator_assert.svh"

   logic                    overlap_so_far_ff, overlap_so_far_in;
   logic                    inside_so_far_ff, inside_so_far_in;
   logic [LOG_SUM_BITS-1:0] log_sum_acc_ff, log_sum_acc_in;
   logic [VOLUME_BITS-1:0]  overlap_product_ff, overlap_product_in;
   logic                    overlap_ovf_acc_ff, overlap_ovf_acc_in;
   logic [VOLUME_BITS-1:0]  extent_product_ff, extent_product_in;
   logic                    extent_ovf_acc_ff, extent_ovf_acc_in;
   logic                    bounds_error_acc_ff, bounds_error_acc_in;
   logic [DIM_BITS-1:0]     dim_count_ff, dim_count_in;

   logic                    bounds_ok;
   logic [COORD_BITS-1:0]   max_low;
   logic [COORD_BITS-1:0]   min_high;
   logic [COORD_BITS-1:0]   overlap_len;
   logic [COORD_BITS-1:0]   extent_len;
   logic                    disjoint;
   logic [LOG_SUM_BITS:0]   log_sum_wide;
   logic [VOLUME_BITS-1:0]  ovl_prod_mul;
   logic                    ovl_ovf_mul;
   logic [VOLUME_BITS-1:0]  ext_prod_mul;
   logic                    ext_ovf_mul;

   assign bounds_ok   = (item.low_one <= item.high_one) && (item.low_two <= item.high_two);
   assign max_low     = (item.low_one > item.low_two) ? item.low_one : item.low_two;
   assign min_high    = (item.high_one < item.high_two) ? item.high_one : item.high_two;
   assign disjoint    = max_low > min_high;
   assign overlap_len = min_high - max_low;
   assign extent_len  = item.high_one - item.low_one;
   assign log_sum_wide = (LOG_SUM_BITS + 1)'(log_sum_acc_ff)
                       + (LOG_SUM_BITS + 1)'(floor_log2(overlap_len));

   bovl_sat_mul u_overlap_mul (
      .prod      (overlap_product_ff),
      .ovf       (overlap_ovf_acc_ff),
      .factor    (overlap_len),
      .prod_next (ovl_prod_mul),
      .ovf_next  (ovl_ovf_mul)
   );

   bovl_sat_mul u_extent_mul (
      .prod      (extent_product_ff),
      .ovf       (extent_ovf_acc_ff),
      .factor    (extent_len),
      .prod_next (ext_prod_mul),
      .ovf_next  (ext_ovf_mul)
   );

   assign finish = step.last_dim || (dim_count_ff == DIM_LAST);

   always_comb begin
      overlap_so_far_in   = overlap_so_far_ff;
      inside_so_far_in    = inside_so_far_ff;
      log_sum_acc_in      = log_sum_acc_ff;
      overlap_product_in  = overlap_product_ff;
      overlap_ovf_acc_in  = overlap_ovf_acc_ff;
      extent_product_in   = extent_product_ff;
      extent_ovf_acc_in   = extent_ovf_acc_ff;
      bounds_error_acc_in = bounds_error_acc_ff;
      if (!bounds_ok) begin
         bounds_error_acc_in = 1'b1;
      end else begin
         if (!((item.low_two >= item.low_one) && (item.high_two <= item.high_one))) begin
            inside_so_far_in = 1'b0;
         end
         if (disjoint) begin
            overlap_so_far_in = 1'b0;
         end else if (overlap_so_far_ff) begin
            if (log_sum_wide[LOG_SUM_BITS]) begin
               log_sum_acc_in = LOG_SUM_MAX;
            end else begin
               log_sum_acc_in = log_sum_wide[LOG_SUM_BITS-1:0];
            end
            overlap_product_in = ovl_prod_mul;
            overlap_ovf_acc_in = ovl_ovf_mul;
         end
         extent_product_in = ext_prod_mul;
         extent_ovf_acc_in = ext_ovf_mul;
      end
   end

   always_comb begin
      result = '0;
      if (bounds_error_acc_in) begin
         result.bad_bounds = 1'b1;
      end else begin
         result.intersects          = overlap_so_far_in;
         result.second_inside_first = inside_so_far_in;
         result.box_volume          = extent_product_in;
         result.box_overflow        = extent_ovf_acc_in;
         if (overlap_so_far_in) begin
            result.overlap_log_sum  = log_sum_acc_in;
            result.overlap_volume   = overlap_product_in;
            result.overlap_overflow = overlap_ovf_acc_in;
         end
      end
   end

   assign dim_count_in = finish ? '0 : dim_count_ff + DIM_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_so_far_ff   <= 1'b1;
         inside_so_far_ff    <= 1'b1;
         log_sum_acc_ff      <= '0;
         overlap_product_ff  <= VOL_ONE;
         overlap_ovf_acc_ff  <= 1'b0;
         extent_product_ff   <= VOL_ONE;
         extent_ovf_acc_ff   <= 1'b0;
         bounds_error_acc_ff <= 1'b0;
         dim_count_ff        <= '0;
      end else if (step.enable) begin
         dim_count_ff <= dim_count_in;
         if (finish) begin
            overlap_so_far_ff   <= 1'b1;
            inside_so_far_ff    <= 1'b1;
            log_sum_acc_ff      <= '0;
            overlap_product_ff  <= VOL_ONE;
            overlap_ovf_acc_ff  <= 1'b0;
            extent_product_ff   <= VOL_ONE;
            extent_ovf_acc_ff   <= 1'b0;
            bounds_error_acc_ff <= 1'b0;
         end else begin
            overlap_so_far_ff   <= overlap_so_far_in;
            inside_so_far_ff    <= inside_so_far_in;
            log_sum_acc_ff      <= log_sum_acc_in;
            overlap_product_ff  <= overlap_product_in;
            overlap_ovf_acc_ff  <= overlap_ovf_acc_in;
            extent_product_ff   <= extent_product_in;
            extent_ovf_acc_ff   <= extent_ovf_acc_in;
            bounds_error_acc_ff <= bounds_error_acc_in;
         end
      end
   end

   `BOVL_ASSERT_NEXT(a_clear_after_finish, step.enable && finish,
      overlap_so_far_ff && inside_so_far_ff && !bounds_error_acc_ff && (dim_count_ff == '0),
      "accumulators not cleared after the closing dimension")
   `BOVL_ASSERT_SAME(a_overlap_ovf_saturated, overlap_ovf_acc_ff,
      overlap_product_ff == VOL_MAX, "overlap overflow set without a saturated product")
   `BOVL_ASSERT_SAME(a_extent_ovf_saturated, extent_ovf_acc_ff,
      extent_product_ff == VOL_MAX, "extent overflow set without a saturated product")

endmodule

/* dv/tb_box_overlap_accumulator.sv */
// ----------------------------------------------------------------------------
// Box overlap accumulator testbench
// Streams box bounds one dimension per item into the block and checks every
// summary item against a cycle-free model of the running overlap, extent and
// bounds state. A directed set covers the extremes, overflow, zero lengths,
// bad bounds and the dimension limit. Random box pairs follow, sent and
// received with random gaps except in a steady stretch of the stream.
// ----------------------------------------------------------------------------
module tb_box_overlap_accumulator;
   import bovl_pkg::*;

   typedef struct {
      item_type bounds;
      logic     last;
   } dim_item_type;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [IN_DATA_BITS-1:0]  req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0] rsp_tdata;

   dim_item_type dim_q[$];
   result_type   summary_q[$];
   logic         req_took = 1'b0;
   int           dims_taken = 0;
   int           mismatch_count = 0;
   int           pairs_seen = 0;
   int           hits_seen = 0;
   int           ovf_seen = 0;
   int           bad_seen = 0;

   // Running state of the pair under comparison.
   logic                   all_overlap;
   logic                   all_inside;
   int                     log_total;
   logic [VOLUME_BITS-1:0] overlap_prod;
   logic                   overlap_sat;
   logic [VOLUME_BITS-1:0] extent_prod;
   logic                   extent_sat;
   logic                   bounds_bad;
   int                     dim_index;

   box_overlap_accumulator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int msb_index(input logic [COORD_BITS-1:0] value);
      int pos;
      pos = 0;
      for (int i = 1; i < COORD_BITS; i++) begin
         if (value[i]) begin
            pos = i;
         end
      end
      return pos;
   endfunction

   task automatic scale_volume(inout logic [VOLUME_BITS-1:0] prod, inout logic sat,
                               input logic [COORD_BITS-1:0] factor);
      logic [2*VOLUME_BITS-1:0] full;
      if (factor == '0) begin
         prod = '0;
         sat = 1'b0;
      end else if (!sat && prod != '0) begin
         full = (2*VOLUME_BITS)'(prod) * (2*VOLUME_BITS)'(factor);
         if (full > (2*VOLUME_BITS)'(VOL_MAX)) begin
            prod = VOL_MAX;
            sat = 1'b1;
         end else begin
            prod = full[VOLUME_BITS-1:0];
         end
      end
   endtask

   task automatic clear_pair();
      all_overlap = 1'b1;
      all_inside = 1'b1;
      log_total = 0;
      overlap_prod = VOLUME_BITS'(1);
      overlap_sat = 1'b0;
      extent_prod = VOLUME_BITS'(1);
      extent_sat = 1'b0;
      bounds_bad = 1'b0;
      dim_index = 0;
   endtask

   task automatic fold_dimension(input item_type b, input logic last, output logic closed,
                                 output result_type summary);
      logic [COORD_BITS-1:0] lo;
      logic [COORD_BITS-1:0] hi;
      logic [COORD_BITS-1:0] len;
      summary = '0;
      if (b.low_one > b.high_one || b.low_two > b.high_two) begin
         bounds_bad = 1'b1;
      end else begin
         lo = (b.low_one > b.low_two) ? b.low_one : b.low_two;
         hi = (b.high_one < b.high_two) ? b.high_one : b.high_two;
         if (!(b.low_two >= b.low_one && b.high_two <= b.high_one)) begin
            all_inside = 1'b0;
         end
         if (lo > hi) begin
            all_overlap = 1'b0;
         end else if (all_overlap) begin
            len = hi - lo;
            log_total = log_total + msb_index(len);
            if (log_total > 255) begin
               log_total = 255;
            end
            scale_volume(overlap_prod, overlap_sat, len);
         end
         scale_volume(extent_prod, extent_sat, b.high_one - b.low_one);
      end
      dim_index++;
      closed = last || dim_index >= MAX_DIMS;
      if (closed) begin
         if (bounds_bad) begin
            summary.bad_bounds = 1'b1;
         end else begin
            summary.intersects = all_overlap;
            summary.second_inside_first = all_inside;
            summary.overlap_log_sum = all_overlap ? LOG_SUM_BITS'(log_total) : '0;
            summary.overlap_volume = all_overlap ? overlap_prod : '0;
            summary.overlap_overflow = all_overlap && overlap_sat;
            summary.box_volume = extent_prod;
            summary.box_overflow = extent_sat;
         end
         clear_pair();
      end
   endtask

   task automatic check_field(input string name, input logic [VOLUME_BITS-1:0] want,
                              input logic [VOLUME_BITS-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Mismatch in %s of summary %0d: expected %h, got %h",
                     name, pairs_seen, want, got);
         end
      end
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      int w;
      w = $urandom_range(COORD_BITS, 1);
      case ($urandom_range(15))
         0: return '0;
         1: return COORD_MAX;
         default: return COORD_BITS'($urandom) & (COORD_MAX >> (COORD_BITS - w));
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_between(input logic [COORD_BITS-1:0] lo,
                                                          input logic [COORD_BITS-1:0] hi);
      logic [63:0] span;
      span = 64'(hi) - 64'(lo) + 64'd1;
      return lo + COORD_BITS'({$urandom, $urandom} % span);
   endfunction

   task automatic push_dim(input logic [COORD_BITS-1:0] l1, input logic [COORD_BITS-1:0] h1,
                           input logic [COORD_BITS-1:0] l2, input logic [COORD_BITS-1:0] h2,
                           input logic last);
      dim_item_type d;
      d.bounds.low_one = l1;
      d.bounds.high_one = h1;
      d.bounds.low_two = l2;
      d.bounds.high_two = h2;
      d.last = last;
      dim_q.push_back(d);
   endtask

   task automatic push_random_dim(input logic broken, input logic last);
      logic [COORD_BITS-1:0] a;
      logic [COORD_BITS-1:0] b;
      logic [COORD_BITS-1:0] l1;
      logic [COORD_BITS-1:0] h1;
      logic [COORD_BITS-1:0] l2;
      logic [COORD_BITS-1:0] h2;
      a = pick_coord();
      b = pick_coord();
      l1 = (a < b) ? a : b;
      h1 = (a < b) ? b : a;
      case ($urandom_range(9))
         0, 1, 2: begin
            l2 = pick_between(l1, h1);
            h2 = pick_between(l2, h1);
         end
         3, 4, 5: begin
            l2 = pick_between(l1, h1);
            h2 = pick_between(l2, COORD_MAX);
         end
         6, 7: begin
            l2 = pick_between('0, l1);
            h2 = pick_between(h1, COORD_MAX);
         end
         default: begin
            a = pick_coord();
            b = pick_coord();
            l2 = (a < b) ? a : b;
            h2 = (a < b) ? b : a;
         end
      endcase
      if (broken) begin
         a = pick_between(COORD_BITS'(1), COORD_MAX);
         b = pick_between('0, a - 1'b1);
         if ($urandom_range(1)) begin
            l1 = a;
            h1 = b;
         end else begin
            l2 = a;
            h2 = b;
         end
      end
      push_dim(l1, h1, l2, h2, last);
   endtask

   function automatic logic steady_phase();
      return dims_taken >= 150 && dims_taken < 260;
   endfunction

   always @(negedge clock) begin
      dim_item_type d;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_phase() || $urandom_range(99) >= 20;
         if (!req_tvalid || req_took) begin
            if (dim_q.size() != 0 && (steady_phase() || $urandom_range(99) >= 20)) begin
               d = dim_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= IN_DATA_BITS'(d.bounds);
               req_tlast <= d.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      logic       closed;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (summary_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected summary item %h", got);
               end
            end else begin
               want = summary_q.pop_front();
               check_field("intersects", 64'(want.intersects), 64'(got.intersects));
               check_field("second_inside_first", 64'(want.second_inside_first),
                           64'(got.second_inside_first));
               check_field("overlap_log_sum", 64'(want.overlap_log_sum),
                           64'(got.overlap_log_sum));
               check_field("overlap_volume", 64'(want.overlap_volume),
                           64'(got.overlap_volume));
               check_field("overlap_overflow", 64'(want.overlap_overflow),
                           64'(got.overlap_overflow));
               check_field("box_volume", 64'(want.box_volume), 64'(got.box_volume));
               check_field("box_overflow", 64'(want.box_overflow), 64'(got.box_overflow));
               check_field("bad_bounds", 64'(want.bad_bounds), 64'(got.bad_bounds));
               pairs_seen++;
               hits_seen += int'(want.intersects);
               ovf_seen += int'(want.overlap_overflow || want.box_overflow);
               bad_seen += int'(want.bad_bounds);
            end
         end
         if (req_tvalid && req_tready) begin
            dims_taken++;
            fold_dimension(item_type'(req_tdata), req_tlast, closed, want);
            if (closed) begin
               summary_q.push_back(want);
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Timeout with %0d summary items outstanding", summary_q.size());
      $display("tb_box_overlap_accumulator NOT OK");
      $finish;
   end

   initial begin
      int n;
      int bad_at;
      int random_dims;
      clear_pair();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-range boxes, then three full dimensions that overflow both products.
      push_dim('0, COORD_MAX, '0, COORD_MAX, 1'b1);
      for (int i = 0; i < 3; i++) begin
         push_dim('0, COORD_MAX, '0, COORD_MAX, i == 2);
      end
      // Overflow followed by a zero-length dimension clears both products.
      for (int i = 0; i < 3; i++) begin
         push_dim('0, COORD_MAX, '0, COORD_MAX, 1'b0);
      end
      push_dim(32'd5, 32'd5, 32'd5, 32'd5, 1'b1);
      // Disjoint, bad bounds in either box, and box two inside box one.
      push_dim(32'd0, 32'd10, 32'd20, 32'd30, 1'b1);
      push_dim(32'd9, 32'd3, 32'd0, 32'd7, 1'b1);
      push_dim(32'd0, 32'd100, 32'd50, 32'd40, 1'b0);
      push_dim(32'd0, 32'd100, 32'd10, 32'd20, 1'b1);
      push_dim(32'd0, 32'd100, 32'd10, 32'd20, 1'b1);
      // Touching intervals give a zero overlap length.
      push_dim(32'd0, 32'd8, 32'd8, 32'd12, 1'b1);
      // Eight dimensions without a closing mark still close the pair.
      for (int i = 0; i < MAX_DIMS; i++) begin
         push_dim(32'd1, 32'd4, 32'd2, 32'd3, 1'b0);
      end
      push_dim(COORD_MAX, COORD_MAX, '0, COORD_MAX, 1'b1);

      while (dim_q.size() != 0 || req_tvalid) @(negedge clock);
      while (summary_q.size() != 0) @(negedge clock);

      random_dims = 0;
      while (random_dims < 450) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(MAX_DIMS + 4, MAX_DIMS + 1)
                                      : $urandom_range(MAX_DIMS, 1);
         bad_at = ($urandom_range(99) < 12) ? $urandom_range(n - 1) : -1;
         for (int i = 0; i < n; i++) begin
            push_random_dim(i == bad_at, i == n - 1);
         end
         random_dims += n;
      end

      while (dim_q.size() != 0 || req_tvalid) @(negedge clock);
      while (summary_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d dimension items and checked %0d box pair summaries.",
               dims_taken, pairs_seen);
      $display("Of these, %0d intersected, %0d overflowed a volume and %0d had bad bounds.",
               hits_seen, ovf_seen, bad_seen);
      if (mismatch_count == 0) begin
         $display("tb_box_overlap_accumulator OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_box_overlap_accumulator NOT OK");
      end
      $finish;
   end

endmodule
